### sv/msg_pkg.sv
// ----------------------------------------------------------------------------
// msg_pkg: shared types and constants of the magic square generator
// Field widths, the result word layout and the small modular reduce helper.
// ----------------------------------------------------------------------------
package msg_pkg;

	localparam int MAX_ORDER = 64;
	localparam int ORDER_W   = 7;
	localparam int IDX_W     = 6;
	localparam int VAL_W     = 13;
	localparam int RED_W     = 9;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             done;
		logic             last;
	} word_t;

	// reduce a value below three times the modulus
	function automatic logic [RED_W-1:0] reduce3(input logic [RED_W-1:0] a,
		input logic [RED_W-1:0] m);
		logic [RED_W-1:0] r;
		r = a;
		if (r >= m) r = r - m;
		if (r >= m) r = r - m;
		return r;
	endfunction

endpackage

### sv/magic_square_generator.sv
// ----------------------------------------------------------------------------
// magic_square_generator: cell-by-cell magic square writer
// Each input word steps the row/column counters and emits the cell writes
// for that position, for odd, doubly even and singly even orders.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready/order) sets the side length n; it is
//   always ready; the user must write it only while the block is idle, which
//   the block does not enforce. Orders above 64 saturate to 64; reset leaves n = 3.
//   Input channel (in_valid/in_ready/restart): restart = 1 starts a new
//   square and emits its first position, restart = 0 advances one position.
//   After reset the block is finished and ignores ticks until a restart.
//   Output channel (out_valid/out_ready/row/col/value/square_done/run_end):
//   one word per cell write; run_end marks the last word of a tick and
//   square_done the final write of the square.
//   The first output word is presented in the cycle after input acceptance.
//   Odd and doubly even orders emit one word per tick; singly even orders
//   emit two words per tick through the single output port, which drains
//   the two-entry result buffer.
//   When the receiver stalls, the buffer holds its words and in_ready drops
//   until the last buffered word is taken.
// ----------------------------------------------------------------------------
module magic_square_generator import msg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ORDER_W-1:0]  order,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [IDX_W-1:0]    row,
	output logic [IDX_W-1:0]    col,
	output logic [VAL_W-1:0]    value,
	output logic                square_done,
	output logic                run_end
);

	logic [ORDER_W-1:0] n_q;
	logic [VAL_W-1:0]   nsq_q;
	logic [IDX_W-1:0]   outer_q, inner_q;
	logic               parity_q, fin_q;
	word_t              buf_q [2];
	logic [1:0]         cnt_q;

	logic               in_fire, out_fire;
	logic [ORDER_W-1:0] n_sat;
	logic [IDX_W-1:0]   i0, j0;
	logic               p0, f0;
	logic [IDX_W-1:0]   h;
	logic [ORDER_W-1:0] lim;
	logic               is_odd, is_de, run, last;
	logic [VAL_W-1:0]   in_prod, k_lin, shift;
	logic [RED_W-1:0]   ox, oy, sk, sx, jj, nn, hh;
	logic [ORDER_W-1:0] odd_f, jn;
	logic [VAL_W-1:0]   v0, v1, va, vb;
	logic               de_x, de_y, toggle;
	word_t              res0, res1;
	logic [1:0]         nres;
	logic [IDX_W-1:0]   outer_d, inner_d;
	logic               parity_d, fin_d;
	word_t              buf_d [2];
	logic [1:0]         cnt_d;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid & in_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_fire  = out_valid & out_ready;
	assign in_ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	assign row         = buf_q[0].row;
	assign col         = buf_q[0].col;
	assign value       = buf_q[0].value;
	assign square_done = buf_q[0].done;
	assign run_end     = buf_q[0].last;

	assign n_sat = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;

	always_comb begin
		i0 = restart ? '0 : outer_q;
		j0 = restart ? '0 : inner_q;
		p0 = restart ? 1'b0 : parity_q;
		f0 = restart ? 1'b0 : fin_q;

		h      = n_q[ORDER_W-1:1];
		is_odd = n_q[0];
		is_de  = (n_q[1:0] == 2'b00);
		lim    = (is_odd || is_de) ? n_q : {1'b0, h};
		run    = !f0 && (n_q != '0) && ({1'b0, i0} < lim) && ({1'b0, j0} < n_q);
		last   = run && ({1'b0, i0} == lim - 1'b1) && ({1'b0, j0} == n_q - 1'b1);

		jj = RED_W'(j0);
		nn = RED_W'(n_q);
		hh = RED_W'(h);

		in_prod = VAL_W'({7'd0, i0} * {6'd0, n_q});
		k_lin   = in_prod + VAL_W'(j0) + 1'b1;

		// odd order
		ox = reduce3(hh + jj + nn - RED_W'(i0), nn);
		oy = reduce3({2'b00, i0, 1'b0} + nn - jj, nn);

		// doubly even order
		de_x = j0[1] ^ j0[0];
		de_y = i0[1] ^ i0[0];

		// singly even order
		sk    = reduce3(hh + RED_W'(i0) - 1'b1, hh);
		sx    = reduce3(sk + hh - 1'b1, hh);
		odd_f = {h - 1'b1 - i0, 1'b1};
		shift = VAL_W'({6'd0, n_q} * {6'd0, odd_f});
		if ((jj == sx) || (jj == nn - sx - 1'b1))
			v0 = in_prod + VAL_W'(n_q) - VAL_W'(j0) - 1'b1;
		else
			v0 = in_prod + VAL_W'(j0) + ((jj == sk) ? shift : '0);
		v1 = nsq_q - in_prod - VAL_W'(j0) - 1'b1
			- ((jj == nn - sk - 1'b1) ? shift : '0);
		va = p0 ? v1 : v0;
		vb = p0 ? v0 : v1;
		toggle = (jj != hh - 1'b1) && (jj != sk - 1'b1) && (jj != nn - sk - 1'b1);

		res0 = '0;
		res1 = '0;
		nres = 2'd0;
		if (run) begin
			if (is_odd) begin
				res0 = '{row: oy[IDX_W-1:0], col: ox[IDX_W-1:0], value: k_lin,
					done: last, last: 1'b1};
				nres = 2'd1;
			end else if (is_de) begin
				res0 = '{row: i0, col: j0,
					value: (de_x == de_y) ? k_lin : nsq_q + 1'b1 - k_lin,
					done: last, last: 1'b1};
				nres = 2'd1;
			end else begin
				res0 = '{row: i0, col: j0, value: va + 1'b1, done: 1'b0, last: 1'b0};
				res1 = '{row: IDX_W'(n_q - 1'b1) - i0, col: IDX_W'(n_q - 1'b1) - j0,
					value: vb + 1'b1, done: last, last: 1'b1};
				nres = 2'd2;
			end
		end

		outer_d  = i0;
		inner_d  = j0;
		parity_d = p0;
		fin_d    = !run || last;
		jn       = {1'b0, j0} + 1'b1;
		if (run) begin
			if (jn >= n_q) begin
				inner_d = '0;
				outer_d = i0 + 1'b1;
			end else begin
				inner_d = jn[IDX_W-1:0];
			end
			if (!is_odd && !is_de && toggle)
				parity_d = !p0;
		end

		buf_d[0] = buf_q[0];
		buf_d[1] = buf_q[1];
		cnt_d    = cnt_q;
		if (in_fire && (nres != 2'd0)) begin
			buf_d[0] = res0;
			buf_d[1] = res1;
			cnt_d    = nres;
		end else if (out_fire) begin
			buf_d[0] = buf_q[1];
			cnt_d    = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= ORDER_W'(3);
			nsq_q    <= VAL_W'(9);
			outer_q  <= '0;
			inner_q  <= '0;
			parity_q <= 1'b0;
			fin_q    <= 1'b1;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_q   <= n_sat;
				nsq_q <= VAL_W'({6'd0, n_sat} * {6'd0, n_sat});
			end
			if (in_fire) begin
				outer_q  <= outer_d;
				inner_q  <= inner_d;
				parity_q <= parity_d;
				fin_q    <= fin_d;
			end
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		buf_q[0] <= buf_d[0];
		buf_q[1] <= buf_d[1];
	end

endmodule

### sv/msg_checker.sv
// ----------------------------------------------------------------------------
// msg_checker: port-level checks of the magic square generator
// Output word hold under stall, word marking, paired word delivery and input ready when empty.
// ----------------------------------------------------------------------------
module msg_checker import msg_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [IDX_W-1:0]    row,
	input logic [IDX_W-1:0]    col,
	input logic [VAL_W-1:0]    value,
	input logic                square_done,
	input logic                run_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row) && $stable(col)
			&& $stable(value) && $stable(square_done) && $stable(run_end))
		else $error("output word changed while stalled");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && square_done |-> run_end)
		else $error("square_done without run_end");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_end |=> out_valid && run_end)
		else $error("second word of a pair not presented");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind magic_square_generator msg_checker u_msg_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the magic square generator
// Runs directed squares over the order corner cases, then random squares,
// partial runs and noise under bursty input and a stalling receiver. Each
// accepted tick is predicted cell by cell and every output word is checked
// in order against the predicted writes.
// ----------------------------------------------------------------------------
module testbench;
	import msg_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD    = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam logic [10:0] RX_PATTERN_BITS = 11'b101_1100_1110;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_LEAN, RX_PATTERN} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ORDER_W-1:0] order = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [IDX_W-1:0]   row;
	logic [IDX_W-1:0]   col;
	logic [VAL_W-1:0]   value;
	logic               square_done;
	logic               run_end;

	// predicted block state
	logic [ORDER_W-1:0] ord_now = ORDER_W'(3);
	int                 at_row = 0;
	int                 at_col = 0;
	bit                 swap_flag = 1'b0;
	bit                 idle_flag = 1'b1;

	bit                 tick_queue[$];
	word_t              pending_cells[$];
	word_t              got;
	word_t              want;
	int                 error_count = 0;
	int                 items_sent = 0;
	int                 quiet_cycles = 0;
	logic               in_took = 1'b0;
	bit                 tx_gappy = 1'b0;
	int                 burst_left = 0;
	int                 gap_left = 0;
	rx_mode_t           rx_mode = RX_FREE;
	int                 rx_phase = 0;
	int                 hold_asked = 0;
	int                 hold_served = 0;
	int                 hold_left = 0;

	magic_square_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.order       (order),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row         (row),
		.col         (col),
		.value       (value),
		.square_done (square_done),
		.run_end     (run_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void queue_cell(input int r, input int c, input int v,
		input bit done, input bit tail);
		word_t w;
		w.row   = IDX_W'(r);
		w.col   = IDX_W'(c);
		w.value = VAL_W'(v);
		w.done  = done;
		w.last  = tail;
		pending_cells.push_back(w);
	endfunction

	function automatic void predict_writes(input bit fresh);
		int n, lim, i, j, h, k, x, y, sh, v0, v1;
		bit last;
		n = (ord_now > MAX_ORDER) ? MAX_ORDER : int'(ord_now);
		if (fresh) begin
			at_row = 0;
			at_col = 0;
			swap_flag = 1'b0;
			idle_flag = 1'b0;
		end
		if (idle_flag || n == 0) begin
			idle_flag = 1'b1;
			return;
		end
		lim = (n % 2 == 1 || n % 4 == 0) ? n : n / 2;
		i = at_row;
		j = at_col;
		if (i >= lim || j >= n) begin
			idle_flag = 1'b1;
			return;
		end
		last = (i == lim - 1) && (j == n - 1);
		if (n % 2 == 1) begin
			x = (n / 2 + j - i + n) % n;
			y = (2 * i - j + n) % n;
			queue_cell(y, x, i * n + j + 1, last, 1'b1);
		end else if (n % 4 == 0) begin
			x = (j % 4 < 2) ? j % 4 : 3 - j % 4;
			y = (i % 4 < 2) ? i % 4 : 3 - i % 4;
			k = i * n + j + 1;
			queue_cell(i, j, (x == y) ? k : n * n + 1 - k, last, 1'b1);
		end else begin
			h = n / 2;
			k = (h + i - 1) % h;
			x = (k + h - 1) % h;
			sh = n * (1 + 2 * (h - 1 - i));
			if (j == x || j == n - x - 1)
				v0 = i * n + (n - j - 1);
			else
				v0 = i * n + j + ((j == k) ? sh : 0);
			v1 = n * n - i * n - j - 1 - ((j == n - k - 1) ? sh : 0);
			queue_cell(i, j, (swap_flag ? v1 : v0) + 1, 1'b0, 1'b0);
			queue_cell(n - i - 1, n - j - 1, (swap_flag ? v0 : v1) + 1, last, 1'b1);
			if (j != h - 1 && j != k - 1 && j != n - k - 1) swap_flag = ~swap_flag;
		end
		j++;
		if (j >= n) begin
			j = 0;
			i++;
		end
		at_row = i;
		at_col = j;
		if (last) idle_flag = 1'b1;
	endfunction

	function automatic int square_ticks(input int ov);
		int n;
		n = (ov > MAX_ORDER) ? MAX_ORDER : ov;
		if (n % 2 == 1 || n % 4 == 0) return n * n;
		return n * (n / 2);
	endfunction

	task automatic note_mismatch(input string msg);
		if (error_count < 100) $display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic run_square(input int len);
		tick_queue.push_back(1'b1);
		for (int t = 1; t < len; t++) tick_queue.push_back(1'b0);
		items_sent += len;
	endtask

	task automatic add_noise(input int len);
		for (int t = 0; t < len; t++) tick_queue.push_back(1'($urandom_range(0, 1)));
		items_sent += len;
	endtask

	task automatic settle();
		@(posedge clk);
		while (tick_queue.size() != 0 || in_valid || pending_cells.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(input logic [ORDER_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		order <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic start_setting(input int ov);
		settle();
		write_order(ORDER_W'(ov));
		rx_mode = rx_mode_t'($urandom_range(0, 3));
		tx_gappy = ($urandom_range(0, 3) != 0);
	endtask

	// sender: bursts of words with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold until taken
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (tick_queue.size() > 0) begin
			restart <= tick_queue.pop_front();
			in_valid <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap_left = tx_gappy ? $urandom_range(0, 10) : 0;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern plus one long hold
	always @(negedge clk) begin
		rx_phase++;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served++;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:    out_ready <= 1'b1;
				RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
				RX_LEAN:    out_ready <= ($urandom_range(0, 7) != 0);
				RX_PATTERN: out_ready <= RX_PATTERN_BITS[rx_phase % 11];
				default:    out_ready <= 1'b1;
			endcase
		end
	end

	// monitor: predict on accepted ticks, check accepted words
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) ord_now = order;
			if (in_valid && in_ready) predict_writes(restart);
			if (out_valid && out_ready) begin
				got = '{row, col, value, square_done, run_end};
				if (pending_cells.size() == 0) begin
					note_mismatch($sformatf("unexpected word row %0d col %0d value %0d",
						row, col, value));
				end else begin
					want = pending_cells.pop_front();
					if (got.row !== want.row)
						note_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
					if (got.col !== want.col)
						note_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
					if (got.value !== want.value)
						note_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
					if (got.done !== want.done)
						note_mismatch($sformatf("square_done %0b, want %0b", got.done,
							want.done));
					if (got.last !== want.last)
						note_mismatch($sformatf("run_end %0b, want %0b", got.last, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int ov, r, len, budget, start, phase_no;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle after reset, then a full square at the reset order
		add_noise(0);
		tick_queue.push_back(1'b0);
		items_sent++;
		run_square(9);
		tick_queue.push_back(1'b0);
		items_sent++;
		start_setting(0);
		run_square(2);
		start_setting(1);
		run_square(2);
		start_setting(2);
		run_square(2);
		start_setting(127);
		run_square(3);
		// leave a square open, then shrink the order under it
		start_setting(6);
		run_square(8);
		start_setting(2);
		tick_queue.push_back(1'b0);
		items_sent++;

		phase_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (phase_no == 2) ov = 10;
			else if (r < 70) ov = $urandom_range(1, 12);
			else if (r < 80) ov = $urandom_range(13, 40);
			else if (r < 88) ov = $urandom_range(41, 64);
			else if (r < 94) ov = $urandom_range(65, 127);
			else ov = 0;
			start_setting(ov);
			if (phase_no == 2) tx_gappy = 1'b0;
			budget = (phase_no == 2) ? 400 : $urandom_range(40, 160);
			start = items_sent;
			while (items_sent - start < budget) begin
				if ($urandom_range(0, 7) == 0) begin
					add_noise($urandom_range(1, 8));
				end else begin
					len = square_ticks(ov) + $urandom_range(0, 2);
					if (len > 150 || $urandom_range(0, 3) == 0)
						len = $urandom_range(1, (len > 150) ? 150 : len + 1);
					if (len < 1) len = 1;
					run_square(len);
				end
				if (phase_no == 2 && hold_asked == 0) hold_asked++;
				if (phase_no % 5 == 3) settle();
			end
			phase_no++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
